// ----- rtl/mlap_pkg.sv -----
// shared types and constants of the mirrored-border cross filter
package mlap_pkg;

  // defaults of the top-level parameters
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int DEF_PIXEL_BITS = 16;

  // fixed field widths
  localparam int VALUE_BITS = 34;
  localparam int DIM_BITS   = 11;
  localparam int COEF_BITS  = 16;

  // register reset values
  localparam logic [DIM_BITS-1:0]         RESET_FRAME_DIM   = 11'd1024;
  localparam logic signed [COEF_BITS-1:0] RESET_CENTER_COEF = 16'sd256;
  localparam logic signed [COEF_BITS-1:0] RESET_SIDE_COEF   = -16'sd64;

  // job queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // window taps carried in a job, named by row (0 = oldest) and column (2 = newest)
  localparam int NUM_SLOTS = 8;
  localparam int SLOT_01   = 0;
  localparam int SLOT_02   = 1;
  localparam int SLOT_10   = 2;
  localparam int SLOT_11   = 3;
  localparam int SLOT_12   = 4;
  localparam int SLOT_20   = 5;
  localparam int SLOT_21   = 6;
  localparam int SLOT_22   = 7;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_CENTER_COEF  = 2'd2,
    REG_SIDE_COEF    = 2'd3
  } cfg_reg_t;

  // kernel weights
  typedef struct packed {
    logic signed [COEF_BITS-1:0] center;
    logic signed [COEF_BITS-1:0] side;
  } coefs_t;

  // position class of a pixel, decided by the front
  typedef struct packed {
    logic top;
    logic left_edge;
    logic row_end;
    logic last_row;
  } pos_flags_t;

  // which of the up to four results of a job is being built
  typedef enum logic [1:0] {
    RES_ABOVE_LEFT = 2'd0,
    RES_ABOVE      = 2'd1,
    RES_LEFT       = 2'd2,
    RES_HERE       = 2'd3
  } res_kind_t;

endpackage

// ----- rtl/mlap_ifs.sv -----
// valid/ready channel interfaces: pixel input, result output, register writes

interface mlap_pix_if
  import mlap_pkg::*;
#(
  parameter int PIXEL_BITS = DEF_PIXEL_BITS
);
  logic                         valid;
  logic                         ready;
  logic signed [PIXEL_BITS-1:0] pixel;

  modport source (output valid, pixel, input ready);
  modport sink   (input valid, pixel, output ready);
endinterface

interface mlap_res_if
  import mlap_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
);
  localparam int COL_BITS = $clog2(MAX_WIDTH);
  localparam int ROW_BITS = $clog2(MAX_HEIGHT);

  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] filtered_value;
  logic [ROW_BITS-1:0]          out_row;
  logic [COL_BITS-1:0]          out_col;
  logic                         last_of_item;
  logic                         end_of_frame;

  modport source (output valid, filtered_value, out_row, out_col, last_of_item, end_of_frame,
                  input ready);
  modport sink   (input valid, filtered_value, out_row, out_col, last_of_item, end_of_frame,
                  output ready);
endinterface

interface mlap_cfg_if
  import mlap_pkg::*;
;
  logic                 valid;
  logic                 ready;
  cfg_reg_t             index;
  logic [COEF_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/mlap_front.sv -----
// front: takes pixels, keeps raster position, line memory and window, issues jobs
module mlap_front
  import mlap_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int PIXEL_BITS = DEF_PIXEL_BITS,
  localparam int COL_BITS  = $clog2(MAX_WIDTH),
  localparam int ROW_BITS  = $clog2(MAX_HEIGHT)
) (
  input  logic                                 clk,
  input  logic                                 rst,
  mlap_pix_if.sink                             pixels,
  input  logic [COL_BITS-1:0]                  col_last,
  input  logic [ROW_BITS-1:0]                  row_last,
  output logic                                 job_valid,
  input  logic                                 job_ready,
  output logic [NUM_SLOTS-1:0][PIXEL_BITS-1:0] job_pix,
  output logic [ROW_BITS-1:0]                  job_row,
  output logic [COL_BITS-1:0]                  job_col,
  output pos_flags_t                           job_flags
);

  localparam int P = PIXEL_BITS;

  logic [COL_BITS-1:0] col;
  logic [ROW_BITS-1:0] row;
  logic                accept;
  logic                row_end;
  logic                last_row;

  logic                s1_valid;
  logic                s1_emit;
  logic                s1_done;
  logic [P-1:0]        s1_pixel;
  logic [COL_BITS-1:0] s1_col;
  logic [ROW_BITS-1:0] s1_row;
  pos_flags_t          s1_flags;

  // each entry holds {row r-2, row r-1} at one column
  logic [2*P-1:0]      line_mem [MAX_WIDTH];
  logic [2*P-1:0]      line_rd;

  logic [P-1:0]        win      [3][3];
  logic [P-1:0]        win_next [3][3];

  assign accept   = pixels.valid && pixels.ready;
  assign row_end  = (col >= col_last);
  assign last_row = (row >= row_last);

  // raster position of the next pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (row_end) begin
        col <= '0;
        row <= last_row ? '0 : row + ROW_BITS'(1);
      end else begin
        col <= col + COL_BITS'(1);
      end
    end
  end

  // stage 1 control, held while the queue is full
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_done) begin
      s1_valid <= 1'b0;
    end
  end

  // stage 1 payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pixel           <= pixels.pixel;
      s1_col             <= col;
      s1_row             <= row;
      s1_emit            <= (row != '0) && (col != '0);
      s1_flags.top       <= (row == ROW_BITS'(1));
      s1_flags.left_edge <= (col == COL_BITS'(1));
      s1_flags.row_end   <= row_end;
      s1_flags.last_row  <= last_row;
    end
  end

  assign s1_done      = s1_valid && (!s1_emit || job_ready);
  assign pixels.ready = !s1_valid || s1_done;

  // line memory: read on accept, write back when the item leaves stage 1
  always_ff @(posedge clk) begin
    if (accept) begin
      line_rd <= line_mem[col];
    end
    if (s1_done) begin
      line_mem[s1_col] <= {line_rd[P-1:0], s1_pixel};
    end
  end

  // window shifted by one column with the new column on the right
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_next[i][0] = win[i][1];
      win_next[i][1] = win[i][2];
    end
    win_next[0][2] = line_rd[2*P-1:P];
    win_next[1][2] = line_rd[P-1:0];
    win_next[2][2] = s1_pixel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win[i][j] <= '0;
        end
      end
    end else if (s1_done) begin
      win <= win_next;
    end
  end

  // job toward the back
  assign job_valid          = s1_valid && s1_emit;
  assign job_pix[SLOT_01]   = win_next[0][1];
  assign job_pix[SLOT_02]   = win_next[0][2];
  assign job_pix[SLOT_10]   = win_next[1][0];
  assign job_pix[SLOT_11]   = win_next[1][1];
  assign job_pix[SLOT_12]   = win_next[1][2];
  assign job_pix[SLOT_20]   = win_next[2][0];
  assign job_pix[SLOT_21]   = win_next[2][1];
  assign job_pix[SLOT_22]   = win_next[2][2];
  assign job_row            = s1_row;
  assign job_col            = s1_col;
  assign job_flags          = s1_flags;

endmodule

// ----- rtl/mlap_queue.sv -----
// small register queue of jobs between front and back
module mlap_queue
  import mlap_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ----- rtl/mlap_back.sv -----
// back: expands a job into its results and computes the weighted cross sums
module mlap_back
  import mlap_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int PIXEL_BITS = DEF_PIXEL_BITS,
  localparam int COL_BITS  = $clog2(MAX_WIDTH),
  localparam int ROW_BITS  = $clog2(MAX_HEIGHT)
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  coefs_t                               coefs,
  input  logic                                 job_valid,
  output logic                                 job_ready,
  input  logic [NUM_SLOTS-1:0][PIXEL_BITS-1:0] job_pix,
  input  logic [ROW_BITS-1:0]                  job_row,
  input  logic [COL_BITS-1:0]                  job_col,
  input  pos_flags_t                           job_flags,
  mlap_res_if.source                           results
);

  localparam int P       = PIXEL_BITS;
  localparam int SIDE_W  = P + 2;
  localparam int CPROD_W = COEF_BITS + P;
  localparam int SPROD_W = COEF_BITS + SIDE_W;
  localparam int SUM_W   = SPROD_W + 1;

  res_kind_t kind;
  res_kind_t kind_next;
  res_kind_t kind_after;
  logic      more;
  logic      adv;
  logic      take;

  logic signed [P-1:0] w01, w02, w10, w11, w12, w20, w21, w22;
  logic signed [P-1:0] up, left, mid, right, down;
  logic signed [SIDE_W-1:0] sides;
  logic [ROW_BITS-1:0] sel_row;
  logic [COL_BITS-1:0] sel_col;

  logic                      b1_valid;
  logic signed [P-1:0]       b1_mid;
  logic signed [SIDE_W-1:0]  b1_sides;
  logic [ROW_BITS-1:0]       b1_row;
  logic [COL_BITS-1:0]       b1_col;
  logic                      b1_last;
  logic                      b1_eof;

  logic                      b2_valid;
  logic signed [CPROD_W-1:0] b2_cprod;
  logic signed [SPROD_W-1:0] b2_sprod;
  logic [ROW_BITS-1:0]       b2_row;
  logic [COL_BITS-1:0]       b2_col;
  logic                      b2_last;
  logic                      b2_eof;

  logic signed [SUM_W-1:0]   sum;

  logic                      o_valid;
  logic signed [VALUE_BITS-1:0] o_value;
  logic [ROW_BITS-1:0]       o_row;
  logic [COL_BITS-1:0]       o_col;
  logic                      o_last;
  logic                      o_eof;

  // whole pipeline moves when the output register is free or being taken
  assign adv       = !o_valid || results.ready;
  assign take      = job_valid && adv;
  assign job_ready = take && !more;

  // result sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      kind <= RES_ABOVE_LEFT;
    end else begin
      kind <= kind_next;
    end
  end

  // which result follows the current one in this job
  always_comb begin
    kind_after = RES_ABOVE_LEFT;
    more       = 1'b0;
    case (kind)
      RES_ABOVE_LEFT: begin
        if (job_flags.row_end) begin
          kind_after = RES_ABOVE;
          more       = 1'b1;
        end else if (job_flags.last_row) begin
          kind_after = RES_LEFT;
          more       = 1'b1;
        end
      end
      RES_ABOVE: begin
        if (job_flags.last_row) begin
          kind_after = RES_LEFT;
          more       = 1'b1;
        end
      end
      RES_LEFT: begin
        if (job_flags.row_end) begin
          kind_after = RES_HERE;
          more       = 1'b1;
        end
      end
      RES_HERE: begin
        more = 1'b0;
      end
      default: begin
        more = 1'b0;
      end
    endcase
    kind_next = kind;
    if (take) begin
      kind_next = more ? kind_after : RES_ABOVE_LEFT;
    end
  end

  assign w01 = $signed(job_pix[SLOT_01]);
  assign w02 = $signed(job_pix[SLOT_02]);
  assign w10 = $signed(job_pix[SLOT_10]);
  assign w11 = $signed(job_pix[SLOT_11]);
  assign w12 = $signed(job_pix[SLOT_12]);
  assign w20 = $signed(job_pix[SLOT_20]);
  assign w21 = $signed(job_pix[SLOT_21]);
  assign w22 = $signed(job_pix[SLOT_22]);

  // neighbor selection with reflected borders
  always_comb begin
    case (kind)
      RES_ABOVE_LEFT: begin
        up      = job_flags.top ? w21 : w01;
        left    = job_flags.left_edge ? w12 : w10;
        mid     = w11;
        right   = w12;
        down    = w21;
        sel_row = job_row - ROW_BITS'(1);
        sel_col = job_col - COL_BITS'(1);
      end
      RES_ABOVE: begin
        up      = job_flags.top ? w22 : w02;
        left    = w11;
        mid     = w12;
        right   = w11;
        down    = w22;
        sel_row = job_row - ROW_BITS'(1);
        sel_col = job_col;
      end
      RES_LEFT: begin
        up      = w11;
        left    = job_flags.left_edge ? w22 : w20;
        mid     = w21;
        right   = w22;
        down    = w11;
        sel_row = job_row;
        sel_col = job_col - COL_BITS'(1);
      end
      default: begin
        up      = w12;
        left    = w21;
        mid     = w22;
        right   = w21;
        down    = w12;
        sel_row = job_row;
        sel_col = job_col;
      end
    endcase
    sides = SIDE_W'(up) + SIDE_W'(left) + SIDE_W'(right) + SIDE_W'(down);
  end

  // valid bits of the three stages
  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
      b2_valid <= 1'b0;
      o_valid  <= 1'b0;
    end else if (adv) begin
      b1_valid <= job_valid;
      b2_valid <= b1_valid;
      o_valid  <= b2_valid;
    end
  end

  assign sum = SUM_W'(b2_cprod) + SUM_W'(b2_sprod);

  // operand, product and sum stages
  always_ff @(posedge clk) begin
    if (adv) begin
      b1_mid   <= mid;
      b1_sides <= sides;
      b1_row   <= sel_row;
      b1_col   <= sel_col;
      b1_last  <= !more;
      b1_eof   <= (kind == RES_HERE);

      b2_cprod <= coefs.center * b1_mid;
      b2_sprod <= coefs.side * b1_sides;
      b2_row   <= b1_row;
      b2_col   <= b1_col;
      b2_last  <= b1_last;
      b2_eof   <= b1_eof;

      o_value  <= VALUE_BITS'(sum);
      o_row    <= b2_row;
      o_col    <= b2_col;
      o_last   <= b2_last;
      o_eof    <= b2_eof;
    end
  end

  assign results.valid          = o_valid;
  assign results.filtered_value = o_value;
  assign results.out_row        = o_row;
  assign results.out_col        = o_col;
  assign results.last_of_item   = o_last;
  assign results.end_of_frame   = o_eof;

endmodule

// ----- rtl/mirror_laplacian_3x3.sv -----
// top level of the streaming 3x3 cross filter with mirrored borders
//
//   channel   modport  request                          when taken
//   pixels    sink     one raster-order pixel           valid && ready
//   results   source   value, row, column, last, eof    valid && ready
//   cfg       sink     register index and write data    valid && ready (ready always high)
//
// A pixel is taken every cycle while the job queue has room; the back delivers
// one result per cycle while the output is not stalled; a job yields one result on
// inner rows, two at the end of an inner row or anywhere on the last row, and four
// on the frame's last pixel. Results pass through stage 1, the queue and the operand,
// product and sum registers before they are offered.
// Reset is synchronous and clears position, window, queue and pipeline; the
// line memory is not cleared and needs no clearing pass. A stalled output
// freezes the back; the four-job queue lets the front keep taking pixels.
module mirror_laplacian_3x3
  import mlap_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
  input  logic       clk,
  input  logic       rst,
  mlap_pix_if.sink   pixels,
  mlap_res_if.source results,
  mlap_cfg_if.sink   cfg
);

  localparam int COL_BITS = $clog2(MAX_WIDTH);
  localparam int ROW_BITS = $clog2(MAX_HEIGHT);
  localparam int JOB_W    = NUM_SLOTS * PIXEL_BITS + ROW_BITS + COL_BITS + $bits(pos_flags_t);

  logic [DIM_BITS-1:0] frame_width;
  logic [DIM_BITS-1:0] frame_height;
  coefs_t              coefs;
  logic [COL_BITS-1:0] col_last;
  logic [ROW_BITS-1:0] row_last;

  logic                                 f_valid;
  logic                                 f_ready;
  logic [NUM_SLOTS-1:0][PIXEL_BITS-1:0] f_pix;
  logic [ROW_BITS-1:0]                  f_row;
  logic [COL_BITS-1:0]                  f_col;
  pos_flags_t                           f_flags;

  logic                                 q_valid;
  logic                                 q_ready;
  logic [NUM_SLOTS-1:0][PIXEL_BITS-1:0] q_pix;
  logic [ROW_BITS-1:0]                  q_row;
  logic [COL_BITS-1:0]                  q_col;
  pos_flags_t                           q_flags;

  logic [JOB_W-1:0]                     push_data;
  logic [JOB_W-1:0]                     pop_data;

  // configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= RESET_FRAME_DIM;
      frame_height <= RESET_FRAME_DIM;
      coefs.center <= RESET_CENTER_COEF;
      coefs.side   <= RESET_SIDE_COEF;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_FRAME_WIDTH:  frame_width  <= cfg.data[DIM_BITS-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg.data[DIM_BITS-1:0];
        REG_CENTER_COEF:  coefs.center <= $signed(cfg.data);
        REG_SIDE_COEF:    coefs.side   <= $signed(cfg.data);
        default: begin
        end
      endcase
    end
  end

  // last column and row, geometry saturated to 2..max
  always_comb begin
    if (frame_width < DIM_BITS'(2)) begin
      col_last = COL_BITS'(1);
    end else if (int'(frame_width) > MAX_WIDTH) begin
      col_last = COL_BITS'(MAX_WIDTH - 1);
    end else begin
      col_last = COL_BITS'(frame_width - DIM_BITS'(1));
    end
    if (frame_height < DIM_BITS'(2)) begin
      row_last = ROW_BITS'(1);
    end else if (int'(frame_height) > MAX_HEIGHT) begin
      row_last = ROW_BITS'(MAX_HEIGHT - 1);
    end else begin
      row_last = ROW_BITS'(frame_height - DIM_BITS'(1));
    end
  end

  // front: position, line memory, window
  mlap_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .pixels    (pixels),
    .col_last  (col_last),
    .row_last  (row_last),
    .job_valid (f_valid),
    .job_ready (f_ready),
    .job_pix   (f_pix),
    .job_row   (f_row),
    .job_col   (f_col),
    .job_flags (f_flags)
  );

  // job queue
  assign push_data = {f_pix, f_row, f_col, f_flags};
  assign {q_pix, q_row, q_col, q_flags} = pop_data;

  mlap_queue #(
    .WIDTH (JOB_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (push_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (pop_data)
  );

  // back: result expansion and arithmetic
  mlap_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .coefs     (coefs),
    .job_valid (q_valid),
    .job_ready (q_ready),
    .job_pix   (q_pix),
    .job_row   (q_row),
    .job_col   (q_col),
    .job_flags (q_flags),
    .results   (results)
  );

endmodule

// ----- rtl/mlap_checker.sv -----
// port-level checks on the result channel, bound to the top level
module mlap_checker
  import mlap_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  localparam int COL_BITS  = $clog2(MAX_WIDTH),
  localparam int ROW_BITS  = $clog2(MAX_HEIGHT)
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  res_valid,
  input logic                  res_ready,
  input logic [VALUE_BITS-1:0] res_value,
  input logic [ROW_BITS-1:0]   res_row,
  input logic [COL_BITS-1:0]   res_col,
  input logic                  res_last,
  input logic                  res_eof
);

  // a stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result withdrawn while stalled");

  // a stalled result keeps its payload
  a_stable: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable(res_value) && $stable(res_row) &&
      $stable(res_col) && $stable(res_last) && $stable(res_eof))
    else $error("result payload changed while stalled");

  // end of frame is the last result of its pixel
  a_eof_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_eof |-> res_last)
    else $error("end of frame without last of item");

  // frame end sits at the bottom right, never on row or column zero
  a_eof_pos: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_eof |-> (res_row != '0) && (res_col != '0))
    else $error("end of frame at an impossible position");

  // nothing is offered right after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result offered after reset");

endmodule

bind mirror_laplacian_3x3 mlap_checker #(
  .MAX_WIDTH  (MAX_WIDTH),
  .MAX_HEIGHT (MAX_HEIGHT)
) u_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (results.valid),
  .res_ready (results.ready),
  .res_value (results.filtered_value),
  .res_row   (results.out_row),
  .res_col   (results.out_col),
  .res_last  (results.last_of_item),
  .res_eof   (results.end_of_frame)
);

// ----- tb/tb_mirror_laplacian_3x3.sv -----
// self-checking testbench of the mirrored-border 3x3 cross filter
module tb_mirror_laplacian_3x3;
  timeunit 1ns;
  timeprecision 1ps;
  import mlap_pkg::*;

  localparam int MAX_W         = 1024;
  localparam int MAX_H         = 1024;
  localparam int PIX_BITS      = 16;
  localparam int SETTLE_CYCLES = 12;
  localparam int STALL_LIMIT   = 1000;
  localparam int RANDOM_PIXELS = 240;
  localparam int SHOW_LIMIT    = 10;
  localparam int WARM_COLS     = 48;

  typedef struct {
    logic signed [VALUE_BITS-1:0] value;
    logic [9:0]                   row;
    logic [9:0]                   col;
    logic                         last;
    logic                         eof;
  } filt_result_t;

  typedef enum logic {STEP_REG, STEP_PIXEL} step_kind_t;

  typedef struct {
    step_kind_t                   kind;
    cfg_reg_t                     reg_idx;
    logic [15:0]                  data;
    logic                         typed;
    logic signed [VALUE_BITS-1:0] want;
  } directed_step_t;

  logic clk;
  logic rst;
  logic calm_tx;
  logic calm_rx;
  int   mismatch_count = 0;
  int   results_seen = 0;
  int   stall_cycles = 0;

  mlap_pix_if #(.PIXEL_BITS(PIX_BITS)) pix_if ();
  mlap_res_if #(.MAX_WIDTH(MAX_W), .MAX_HEIGHT(MAX_H)) res_if ();
  mlap_cfg_if cfg_if ();

  mirror_laplacian_3x3 #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H),
    .PIXEL_BITS(PIX_BITS)
  ) u_top (
    .clk    (clk),
    .rst    (rst),
    .pixels (pix_if),
    .results(res_if),
    .cfg    (cfg_if)
  );

  // filter state mirrored on the testbench side
  logic signed [PIX_BITS-1:0]  line_prev [MAX_W];
  logic signed [PIX_BITS-1:0]  line_older [MAX_W];
  logic signed [PIX_BITS-1:0]  tap [3][3];
  int unsigned                 col_pos;
  int unsigned                 row_pos;
  logic [DIM_BITS-1:0]         width_reg;
  logic [DIM_BITS-1:0]         height_reg;
  logic signed [COEF_BITS-1:0] center_w;
  logic signed [COEF_BITS-1:0] side_w;

  filt_result_t filtered_due [$];

  // constant frames give results that are read off directly: p * (center + 4 * side)
  directed_step_t plan [30] = '{
    '{STEP_REG,   REG_FRAME_WIDTH,  16'd0,     1'b0, 34'sd0},
    '{STEP_REG,   REG_FRAME_HEIGHT, 16'd1,     1'b0, 34'sd0},
    '{STEP_PIXEL, REG_FRAME_WIDTH,  16'd100,   1'b0, 34'sd0},
    '{STEP_PIXEL, REG_FRAME_WIDTH,  16'd100,   1'b0, 34'sd0},
    '{STEP_PIXEL, REG_FRAME_WIDTH,  16'd100,   1'b0, 34'sd0},
    '{STEP_PIXEL, REG_FRAME_WIDTH,  16'd100,   1'b1, 34'sd0},
    '{STEP_REG,   REG_CENTER_COEF,  16'h7FFF,  1'b0, 34'sd0},
    '{STEP_REG,   REG_SIDE_COEF,    16'h8000,  1'b0, 34'sd0},
    '{STEP_PIXEL, REG_FRAME_WIDTH,  16'h7FFF,  1'b0, 34'sd0},
    '{STEP_PIXEL, REG_FRAME_WIDTH,  16'h7FFF,  1'b0, 34'sd0},
    '{STEP_PIXEL, REG_FRAME_WIDTH,  16'h7FFF,  1'b0, 34'sd0},
    '{STEP_PIXEL, REG_FRAME_WIDTH,  16'h7FFF,  1'b1, -34'sd3221159935},
    '{STEP_REG,   REG_CENTER_COEF,  16'h8000,  1'b0, 34'sd0},
    '{STEP_PIXEL, REG_FRAME_WIDTH,  16'h8000,  1'b0, 34'sd0},
    '{STEP_PIXEL, REG_FRAME_WIDTH,  16'h8000,  1'b0, 34'sd0},
    '{STEP_PIXEL, REG_FRAME_WIDTH,  16'h8000,  1'b0, 34'sd0},
    '{STEP_PIXEL, REG_FRAME_WIDTH,  16'h8000,  1'b1, 34'sd5368709120},
    '{STEP_REG,   REG_FRAME_WIDTH,  16'd3,     1'b0, 34'sd0},
    '{STEP_REG,   REG_FRAME_HEIGHT, 16'd3,     1'b0, 34'sd0},
    '{STEP_REG,   REG_CENTER_COEF,  16'd3,     1'b0, 34'sd0},
    '{STEP_REG,   REG_SIDE_COEF,    16'hFFFB,  1'b0, 34'sd0},
    '{STEP_PIXEL, REG_FRAME_WIDTH,  16'd1,     1'b0, 34'sd0},
    '{STEP_PIXEL, REG_FRAME_WIDTH,  16'hFFFE,  1'b0, 34'sd0},
    '{STEP_PIXEL, REG_FRAME_WIDTH,  16'd300,   1'b0, 34'sd0},
    '{STEP_PIXEL, REG_FRAME_WIDTH,  16'h7FFF,  1'b0, 34'sd0},
    '{STEP_PIXEL, REG_FRAME_WIDTH,  16'd0,     1'b0, 34'sd0},
    '{STEP_PIXEL, REG_FRAME_WIDTH,  16'h8000,  1'b0, 34'sd0},
    '{STEP_PIXEL, REG_FRAME_WIDTH,  16'd77,    1'b0, 34'sd0},
    '{STEP_PIXEL, REG_FRAME_WIDTH,  16'hFC18,  1'b0, 34'sd0},
    '{STEP_PIXEL, REG_FRAME_WIDTH,  16'd5,     1'b0, 34'sd0}
  };

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // weighted cross sum, exact in 34 bits
  function automatic logic signed [VALUE_BITS-1:0] cross_sum(
    input logic signed [PIX_BITS-1:0] up, left, mid, right, down
  );
    longint sides;
    longint acc;
    sides = longint'(up) + longint'(left) + longint'(right) + longint'(down);
    acc = longint'(center_w) * longint'(mid) + longint'(side_w) * sides;
    return acc[VALUE_BITS-1:0];
  endfunction

  // advance the filter by one pixel and queue the results it releases
  task automatic cross_filter_step(input logic signed [PIX_BITS-1:0] px, input logic typed,
                                   input logic signed [VALUE_BITS-1:0] want);
    filt_result_t res [4];
    int           n;
    int unsigned  w, h, c, r, idx;
    logic         row_end, last_row, top, ledge;
    w = (width_reg < 2) ? 2 : (width_reg > MAX_W) ? MAX_W : width_reg;
    h = (height_reg < 2) ? 2 : (height_reg > MAX_H) ? MAX_H : height_reg;
    c = col_pos;
    r = row_pos;
    idx = c % MAX_W;
    row_end = (c >= w - 1);
    last_row = (r >= h - 1);
    n = 0;
    for (int i = 0; i < 3; i++) begin
      tap[i][0] = tap[i][1];
      tap[i][1] = tap[i][2];
    end
    tap[0][2] = line_older[idx];
    tap[1][2] = line_prev[idx];
    tap[2][2] = px;
    line_older[idx] = line_prev[idx];
    line_prev[idx] = px;
    // reflection: row -1 reads row 1, column -1 reads column 1, the far edges likewise
    if (r >= 1 && c >= 1) begin
      top = (r == 1);
      ledge = (c == 1);
      res[n] = '{cross_sum(top ? tap[2][1] : tap[0][1], ledge ? tap[1][2] : tap[1][0],
                           tap[1][1], tap[1][2], tap[2][1]),
                 10'(r - 1), 10'(c - 1), 1'b0, 1'b0};
      n++;
      if (row_end) begin
        res[n] = '{cross_sum(top ? tap[2][2] : tap[0][2], tap[1][1], tap[1][2], tap[1][1],
                             tap[2][2]),
                   10'(r - 1), 10'(c), 1'b0, 1'b0};
        n++;
      end
      if (last_row) begin
        res[n] = '{cross_sum(tap[1][1], ledge ? tap[2][2] : tap[2][0], tap[2][1], tap[2][2],
                             tap[1][1]),
                   10'(r), 10'(c - 1), 1'b0, 1'b0};
        n++;
        if (row_end) begin
          res[n] = '{cross_sum(tap[1][2], tap[2][1], tap[2][2], tap[2][1], tap[1][2]),
                     10'(r), 10'(c), 1'b0, 1'b1};
          n++;
        end
      end
    end
    if (n > 0) res[n - 1].last = 1'b1;
    for (int i = 0; i < n; i++) begin
      if (typed) res[i].value = want;
      filtered_due = {filtered_due, res[i]};
    end
    // raster position of the next pixel
    if (row_end) begin
      col_pos = 0;
      row_pos = last_row ? 0 : ((r + 1) & 10'h3FF);
    end else begin
      col_pos = (c + 1) & 10'h3FF;
    end
  endtask

  // one pixel request, entered and left at a falling edge
  task automatic send_pixel(input logic [PIX_BITS-1:0] px, input logic typed,
                            input logic signed [VALUE_BITS-1:0] want);
    int gap;
    gap = calm_tx ? 0 : $urandom_range(5);
    if (gap > 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pix_if.valid <= 1'b1;
    pix_if.pixel <= px;
    do @(posedge clk); while (!pix_if.ready);
    cross_filter_step(px, typed, want);
    @(negedge clk);
  endtask

  // hold pixels until every queued result is out and the pipeline has settled
  task automatic drain_results();
    pix_if.valid <= 1'b0;
    while (filtered_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // register write request
  task automatic write_reg(input cfg_reg_t idx, input logic [COEF_BITS-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= value;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      REG_FRAME_WIDTH:  width_reg = value[DIM_BITS-1:0];
      REG_FRAME_HEIGHT: height_reg = value[DIM_BITS-1:0];
      REG_CENTER_COEF:  center_w = value;
      REG_SIDE_COEF:    side_w = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_if.valid <= 1'b0;
    @(negedge clk);
  endtask

  // random pixels until the frame wraps, optionally reshaping it once on the way
  task automatic run_frame(input int cut, output int sent);
    sent = 0;
    do begin
      if (sent == cut) begin
        drain_results();
        write_reg(REG_FRAME_WIDTH, 16'($urandom_range(10, 2)));
        write_reg(REG_FRAME_HEIGHT, 16'($urandom_range(6, 2)));
      end
      send_pixel(16'($urandom), 1'b0, '0);
      sent++;
    end while (col_pos != 0 || row_pos != 0);
  endtask

  function automatic logic [COEF_BITS-1:0] pick_coef();
    case ($urandom_range(5))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0100;
      default: return 16'($urandom);
    endcase
  endfunction

  // result side: random stalls with calm stretches
  initial begin
    int gap;
    res_if.ready = 1'b0;
    @(negedge clk);
    forever begin
      gap = calm_rx ? 0 : $urandom_range(5);
      if (gap > 0) begin
        res_if.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (!res_if.valid);
      @(negedge clk);
    end
  end

  // compare each accepted result with the oldest one due
  always @(posedge clk) begin
    filt_result_t want;
    filt_result_t got;
    if (!rst && res_if.valid && res_if.ready) begin
      got = '{res_if.filtered_value, res_if.out_row, res_if.out_col, res_if.last_of_item,
              res_if.end_of_frame};
      results_seen++;
      if (filtered_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= SHOW_LIMIT)
          $display("result %0d not expected: value %0d row %0d col %0d last %0b eof %0b",
                   results_seen, got.value, got.row, got.col, got.last, got.eof);
      end else begin
        want = filtered_due.pop_front();
        if (got.value !== want.value || got.row !== want.row || got.col !== want.col ||
            got.last !== want.last || got.eof !== want.eof) begin
          mismatch_count++;
          if (mismatch_count <= SHOW_LIMIT)
            $display({"result %0d: expected value %0d row %0d col %0d last %0b eof %0b, ",
                      "got value %0d row %0d col %0d last %0b eof %0b"},
                     results_seen, want.value, want.row, want.col, want.last, want.eof,
                     got.value, got.row, got.col, got.last, got.eof);
        end
      end
    end
  end

  // watchdog on cycles without any accepted request
  always @(posedge clk) begin
    if (rst || (pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("[mirror_laplacian_3x3] ERROR");
      $finish;
    end
  end

  // stimulus
  initial begin
    int sent;
    int random_total;
    int unsigned fw, fh, w, h;
    int cut;
    rst = 1'b1;
    pix_if.valid = 1'b0;
    pix_if.pixel = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_FRAME_WIDTH;
    cfg_if.data = '0;
    calm_tx = 1'b0;
    calm_rx = 1'b0;
    random_total = 0;
    width_reg = RESET_FRAME_DIM;
    height_reg = RESET_FRAME_DIM;
    center_w = RESET_CENTER_COEF;
    side_w = RESET_SIDE_COEF;
    col_pos = 0;
    row_pos = 0;
    for (int i = 0; i < MAX_W; i++) begin
      line_prev[i] = '0;
      line_older[i] = '0;
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) tap[i][j] = '0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed frames: saturated geometry, reset weights, weight and pixel extremes
    foreach (plan[i]) begin
      if (plan[i].kind == STEP_REG) begin
        drain_results();
        write_reg(plan[i].reg_idx, plan[i].data);
      end else begin
        send_pixel(plan[i].data, plan[i].typed, plan[i].want);
      end
    end

    // saturating width and height, then reshaped narrower in the middle of the first row;
    // the frame writes its columns three times, so later geometry changes never read an
    // unwritten column
    drain_results();
    write_reg(REG_FRAME_WIDTH, 16'd2047);
    write_reg(REG_FRAME_HEIGHT, 16'd2047);
    write_reg(REG_CENTER_COEF, pick_coef());
    write_reg(REG_SIDE_COEF, pick_coef());
    repeat (WARM_COLS) send_pixel(16'($urandom), 1'b0, '0);
    drain_results();
    write_reg(REG_FRAME_WIDTH, 16'(WARM_COLS));
    write_reg(REG_FRAME_HEIGHT, 16'd3);
    run_frame(-1, sent);

    // random small frames, some reshaped mid-frame
    while (random_total < RANDOM_PIXELS) begin
      calm_tx = ($urandom_range(3) == 0);
      calm_rx = ($urandom_range(3) == 0);
      drain_results();
      fw = ($urandom_range(4) != 0) ? $urandom_range(8, 2) : $urandom_range(40, 9);
      fh = $urandom_range(6, 2);
      if ($urandom_range(9) == 0) fw = $urandom_range(1);
      if ($urandom_range(9) == 0) fh = $urandom_range(1);
      write_reg(REG_FRAME_WIDTH, 16'(fw));
      write_reg(REG_FRAME_HEIGHT, 16'(fh));
      if ($urandom_range(1) == 0) begin
        write_reg(REG_CENTER_COEF, pick_coef());
        write_reg(REG_SIDE_COEF, pick_coef());
      end
      w = (fw < 2) ? 2 : fw;
      h = (fh < 2) ? 2 : fh;
      cut = ($urandom_range(3) == 0) ? int'($urandom_range(w * h - 1, 1)) : -1;
      run_frame(cut, sent);
      random_total += sent;
    end

    drain_results();
    if (mismatch_count == 0) begin
      $display("[mirror_laplacian_3x3] OK");
    end else begin
      $display("[mirror_laplacian_3x3] ERROR");
    end
    $finish;
  end

endmodule
